// ===== design/pwb_pkg.sv =====
// Shared constants, types and saturation helpers for the particle wall bounce step.
package pwb_pkg;

  localparam int DEF_MAX_WALLS = 8;
  localparam int DEF_FRAC_BITS = 16;
  localparam int COEF_BITS     = 30;
  localparam int MUL_W         = 33;
  localparam int PROD_W        = 66;
  localparam int DIV_W         = 64;
  localparam int QUO_W         = COEF_BITS + 1;

  localparam logic [30:0] ARENA_W_RST = 31'd52428800;
  localparam logic [30:0] ARENA_H_RST = 31'd39321600;

  localparam logic [1:0] REG_ARENA_W    = 2'd0;
  localparam logic [1:0] REG_ARENA_H    = 2'd1;
  localparam logic [1:0] REG_WALL_COUNT = 2'd2;

  localparam logic REQ_STEP = 1'b0;
  localparam logic REQ_WALL = 1'b1;

  typedef struct packed {
    logic signed [31:0] sx;
    logic signed [31:0] sy;
    logic signed [31:0] ex;
    logic signed [31:0] ey;
  } wall_t;

  // Saturate to the signed 32-bit range.
  function automatic logic signed [31:0] sat32(input logic signed [PROD_W-1:0] v);
    logic signed [PROD_W-1:0] hi;
    logic signed [PROD_W-1:0] lo;
    hi = PROD_W'(33'sh0_7FFF_FFFF);
    lo = -hi - PROD_W'(1);
    if (v > hi) return 32'sh7FFF_FFFF;
    else if (v < lo) return 32'sh8000_0000;
    else return v[31:0];
  endfunction

  // Clamp magnitude to 2^31-1.
  function automatic logic signed [31:0] clamp31(input logic signed [PROD_W-1:0] v);
    logic signed [PROD_W-1:0] hi;
    hi = PROD_W'(33'sh0_7FFF_FFFF);
    if (v > hi) return 32'sh7FFF_FFFF;
    else if (v < -hi) return -32'sh7FFF_FFFF;
    else return v[31:0];
  endfunction

  // Clamp magnitude to 2^31.
  function automatic logic signed [32:0] clamp32(input logic signed [PROD_W-1:0] v);
    logic signed [PROD_W-1:0] hi;
    hi = PROD_W'(34'sh0_8000_0000);
    if (v > hi) return 33'sh0_8000_0000;
    else if (v < -hi) return -33'sh0_8000_0000;
    else return v[32:0];
  endfunction

endpackage

// ===== design/pwb_mul.sv =====
// Shared signed multiplier with a registered product.
module pwb_mul (
  input  logic                                   clk_i,
  input  logic signed [pwb_pkg::MUL_W-1:0]       a_i,
  input  logic signed [pwb_pkg::MUL_W-1:0]       b_i,
  output logic signed [pwb_pkg::PROD_W-1:0]      p_o
);

  logic signed [pwb_pkg::PROD_W-1:0] p_q;

  always_ff @(posedge clk_i) begin
    p_q <= a_i * b_i;
  end

  assign p_o = p_q;

endmodule

// ===== design/pwb_div.sv =====
// Restoring divider giving floor(num * 2^COEF_BITS / den), one quotient bit per cycle.
module pwb_div (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start_i,
  input  logic [pwb_pkg::DIV_W-1:0]         num_i,
  input  logic [pwb_pkg::DIV_W-1:0]         den_i,
  output logic                              done_o,
  output logic [pwb_pkg::QUO_W-1:0]         quo_o
);

  localparam int RW = pwb_pkg::DIV_W + 1;

  logic          busy_q;
  logic          done_q;
  logic [4:0]    cnt_q;
  logic [RW-1:0] rem_q;
  logic [RW-1:0] den_q;
  logic [pwb_pkg::QUO_W-1:0] quo_q;
  logic [RW-1:0] shifted;
  logic          ge;

  // The first step compares the numerator itself, later steps shift in a zero.
  always_comb begin
    shifted = (cnt_q == 5'd0) ? rem_q : {rem_q[RW-2:0], 1'b0};
    ge      = shifted >= den_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 5'd1;
        if (cnt_q == 5'(pwb_pkg::COEF_BITS)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= RW'(num_i);
      den_q <= RW'(den_i);
      quo_q <= '0;
    end else if (busy_q) begin
      rem_q <= ge ? shifted - den_q : shifted;
      quo_q <= {quo_q[pwb_pkg::QUO_W-2:0], ge};
    end
  end

  assign done_o = done_q;
  assign quo_o  = quo_q;

endmodule

// ===== design/particle_wall_bounce_step.sv =====
// Top level: sequencer, wall memory and registers around the shared multiplier and divider.
//
//   channel   direction  handshake              payload
//   in        input      in_valid_i/in_ready_o   req_type_i .. seg_end_y_i
//   out       output     out_valid_o/out_ready_i new_x_o .. wall_hits_o
//   cfg       input      cfg_we_i                cfg_idx_i, cfg_wdata_i
//
// A wall write leaves the input open. A particle step keeps the input closed until its result
// is taken into the output register; each wall tested costs least for a zero-length wall,
// more when the closest point is an end point, more again when it lies inside the segment
// (one division), and a hit adds two divisions and the velocity rotation on the one multiplier.
// Reset clears the control state and the configuration registers; the wall memory holds garbage
// until written. A result waits in the output register while the next item is taken;
// the sequencer stalls in its last state only when that register is still full.
module particle_wall_bounce_step #(
  parameter int MAX_WALLS = pwb_pkg::DEF_MAX_WALLS,
  parameter int FRAC_BITS = pwb_pkg::DEF_FRAC_BITS
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [1:0]         cfg_idx_i,
  input  logic [30:0]        cfg_wdata_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic               req_type_i,
  input  logic [2:0]         wall_index_i,
  input  logic signed [31:0] pos_x_i,
  input  logic signed [31:0] pos_y_i,
  input  logic signed [31:0] vel_x_i,
  input  logic signed [31:0] vel_y_i,
  input  logic [30:0]        particle_radius_i,
  input  logic [30:0]        time_step_i,
  input  logic signed [31:0] seg_start_x_i,
  input  logic signed [31:0] seg_start_y_i,
  input  logic signed [31:0] seg_end_x_i,
  input  logic signed [31:0] seg_end_y_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic signed [31:0] new_x_o,
  output logic signed [31:0] new_y_o,
  output logic signed [31:0] new_vx_o,
  output logic signed [31:0] new_vy_o,
  output logic [1:0]         edge_hits_o,
  output logic [7:0]         wall_hits_o
);

  localparam int PW   = pwb_pkg::PROD_W;
  localparam int MW   = pwb_pkg::MUL_W;
  localparam int CB   = pwb_pkg::COEF_BITS;
  localparam int IDXW = (MAX_WALLS > 1) ? $clog2(MAX_WALLS) : 1;

  localparam logic [4:0] ST_IDLE = 5'd0;
  localparam logic [4:0] ST_MX   = 5'd1;
  localparam logic [4:0] ST_MY   = 5'd2;
  localparam logic [4:0] ST_ED0  = 5'd3;
  localparam logic [4:0] ST_ED1  = 5'd4;
  localparam logic [4:0] ST_WRD  = 5'd5;
  localparam logic [4:0] ST_WD   = 5'd6;
  localparam logic [4:0] ST_M1   = 5'd7;
  localparam logic [4:0] ST_M2   = 5'd8;
  localparam logic [4:0] ST_M3   = 5'd9;
  localparam logic [4:0] ST_M4   = 5'd10;
  localparam logic [4:0] ST_M5   = 5'd11;
  localparam logic [4:0] ST_M6   = 5'd12;
  localparam logic [4:0] ST_DV   = 5'd13;
  localparam logic [4:0] ST_T1   = 5'd14;
  localparam logic [4:0] ST_T2   = 5'd15;
  localparam logic [4:0] ST_T3   = 5'd16;
  localparam logic [4:0] ST_WE   = 5'd17;
  localparam logic [4:0] ST_S1   = 5'd18;
  localparam logic [4:0] ST_S2   = 5'd19;
  localparam logic [4:0] ST_S3   = 5'd20;
  localparam logic [4:0] ST_S4   = 5'd21;
  localparam logic [4:0] ST_DC   = 5'd22;
  localparam logic [4:0] ST_DS   = 5'd23;
  localparam logic [4:0] ST_R1   = 5'd24;
  localparam logic [4:0] ST_R2   = 5'd25;
  localparam logic [4:0] ST_R3   = 5'd26;
  localparam logic [4:0] ST_R4   = 5'd27;
  localparam logic [4:0] ST_R5   = 5'd28;
  localparam logic [4:0] ST_NXT  = 5'd29;
  localparam logic [4:0] ST_DONE = 5'd30;

  // Configuration.
  logic [30:0] arena_w_q, arena_h_q;
  logic [3:0]  wall_count_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      arena_w_q    <= pwb_pkg::ARENA_W_RST;
      arena_h_q    <= pwb_pkg::ARENA_H_RST;
      wall_count_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        pwb_pkg::REG_ARENA_W:    arena_w_q    <= cfg_wdata_i;
        pwb_pkg::REG_ARENA_H:    arena_h_q    <= cfg_wdata_i;
        pwb_pkg::REG_WALL_COUNT: wall_count_q <= cfg_wdata_i[3:0];
        default: ;
      endcase
    end
  end

  // Control and datapath registers.
  logic [4:0]  state_q, state_d;
  logic [6:0]  idx_q;
  logic [6:0]  n_walls;
  logic signed [31:0] x_q, y_q, vx_q, vy_q, nvx_q;
  logic [30:0] r_q, dt_q;
  logic [1:0]  edges_q;
  logic [7:0]  walls_q;
  logic signed [31:0] dx_q, dy_q, px_q, py_q;
  logic [62:0] dx2_q, dy2_q;
  logic [63:0] len2_q;
  logic signed [PW-1:0] dxy_q, acc_q;
  logic signed [33:0] qx_q, qy_q;
  logic signed [32:0] exd_q, eyd_q;
  logic [pwb_pkg::QUO_W-1:0] t_q;
  logic signed [31:0] c_q, s_q;
  logic out_valid_q;
  logic signed [31:0] ox_q, oy_q, ovx_q, ovy_q;
  logic [1:0]  oedge_q;
  logic [7:0]  owall_q;

  // Wall memory.
  pwb_pkg::wall_t mem_q [MAX_WALLS];
  pwb_pkg::wall_t rd_q;
  logic [6:0] widx;
  logic       accept;

  assign accept = in_valid_i && in_ready_o;
  assign widx   = 7'(wall_index_i);

  always_ff @(posedge clk_i) begin
    if (accept && req_type_i == pwb_pkg::REQ_WALL && widx < 7'(MAX_WALLS)) begin
      mem_q[widx[IDXW-1:0]] <= '{sx: seg_start_x_i, sy: seg_start_y_i,
                                 ex: seg_end_x_i,   ey: seg_end_y_i};
    end
    rd_q <= mem_q[idx_q[IDXW-1:0]];
  end

  // Shared units.
  logic signed [MW-1:0] mul_a, mul_b;
  logic signed [PW-1:0] mul_p;
  logic                 div_start, div_done;
  logic [63:0]          div_num;
  logic [pwb_pkg::QUO_W-1:0] div_quo;

  pwb_mul u_mul (.clk_i(clk_i), .a_i(mul_a), .b_i(mul_b), .p_o(mul_p));

  pwb_div u_div (
    .clk_i(clk_i), .rst_ni(rst_ni), .start_i(div_start), .num_i(div_num),
    .den_i(len2_q), .done_o(div_done), .quo_o(div_quo)
  );

  // Derived values.
  logic signed [PW-1:0] nx, ny, dot, cn, xr, yr, sum_acc;
  logic signed [PW-1:0] abs_dxy2;

  assign n_walls = (7'(wall_count_q) < 7'(MAX_WALLS)) ? 7'(wall_count_q) : 7'(MAX_WALLS);
  assign nx      = PW'(x_q) + PW'(vx_q);
  assign ny      = PW'(y_q) + PW'(vy_q);
  assign dot     = acc_q + mul_p;
  assign sum_acc = acc_q + mul_p;
  assign cn      = PW'(dx2_q) - PW'(dy2_q);
  assign xr      = PW'(x_q) - PW'(r_q);
  assign yr      = PW'(y_q) - PW'(r_q);
  assign abs_dxy2 = (dxy_q < 0) ? -(dxy_q <<< 1) : (dxy_q <<< 1);

  assign in_ready_o = (state_q == ST_IDLE);

  always_comb begin
    mul_a     = '0;
    mul_b     = '0;
    div_start = 1'b0;
    div_num   = '0;
    state_d   = state_q;
    unique case (state_q)
      ST_IDLE: if (accept && req_type_i == pwb_pkg::REQ_STEP) state_d = ST_MX;
      ST_MX: begin
        mul_a = MW'(vx_q); mul_b = $signed(MW'(dt_q)); state_d = ST_MY;
      end
      ST_MY: begin
        mul_a = MW'(vy_q); mul_b = $signed(MW'(dt_q)); state_d = ST_ED0;
      end
      ST_ED0: state_d = ST_ED1;
      ST_ED1: state_d = (n_walls == 7'd0) ? ST_DONE : ST_WRD;
      ST_WRD: state_d = ST_WD;
      ST_WD:  state_d = ST_M1;
      ST_M1: begin mul_a = MW'(dx_q); mul_b = MW'(dx_q); state_d = ST_M2; end
      ST_M2: begin mul_a = MW'(dy_q); mul_b = MW'(dy_q); state_d = ST_M3; end
      ST_M3: begin mul_a = MW'(dx_q); mul_b = MW'(dy_q); state_d = ST_M4; end
      ST_M4: begin
        if (len2_q == 64'd0) begin
          state_d = ST_NXT;
        end else begin
          mul_a = MW'(px_q); mul_b = MW'(dx_q); state_d = ST_M5;
        end
      end
      ST_M5: begin mul_a = MW'(py_q); mul_b = MW'(dy_q); state_d = ST_M6; end
      ST_M6: begin
        if (dot <= 0 || dot >= PW'(len2_q)) begin
          state_d = ST_WE;
        end else begin
          div_start = 1'b1; div_num = dot[63:0]; state_d = ST_DV;
        end
      end
      ST_DV: if (div_done) state_d = ST_T1;
      ST_T1: begin mul_a = MW'(dx_q); mul_b = $signed(MW'(t_q)); state_d = ST_T2; end
      ST_T2: begin mul_a = MW'(dy_q); mul_b = $signed(MW'(t_q)); state_d = ST_T3; end
      ST_T3: state_d = ST_WE;
      ST_WE: state_d = ST_S1;
      ST_S1: begin mul_a = exd_q; mul_b = exd_q; state_d = ST_S2; end
      ST_S2: begin mul_a = eyd_q; mul_b = eyd_q; state_d = ST_S3; end
      ST_S3: begin
        mul_a = $signed(MW'(r_q)); mul_b = $signed(MW'(r_q)); state_d = ST_S4;
      end
      ST_S4: begin
        // The accumulator holds the squared distance and the product the squared radius.
        if (acc_q <= mul_p) begin
          div_start = 1'b1;
          div_num   = (cn < 0) ? 64'(-cn) : 64'(cn);
          state_d   = ST_DC;
        end else begin
          state_d = ST_NXT;
        end
      end
      ST_DC: begin
        if (div_done) begin
          div_start = 1'b1; div_num = abs_dxy2[63:0]; state_d = ST_DS;
        end
      end
      ST_DS: if (div_done) state_d = ST_R1;
      ST_R1: begin mul_a = MW'(vx_q); mul_b = MW'(c_q); state_d = ST_R2; end
      ST_R2: begin mul_a = MW'(vy_q); mul_b = MW'(s_q); state_d = ST_R3; end
      ST_R3: begin mul_a = MW'(vx_q); mul_b = MW'(s_q); state_d = ST_R4; end
      ST_R4: begin mul_a = MW'(vy_q); mul_b = MW'(c_q); state_d = ST_R5; end
      ST_R5: state_d = ST_NXT;
      ST_NXT: state_d = (idx_q + 7'd1 >= n_walls) ? ST_DONE : ST_WRD;
      ST_DONE: if (!out_valid_q || out_ready_i) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == ST_DONE && (!out_valid_q || out_ready_i)) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_IDLE: begin
        x_q <= pos_x_i; y_q <= pos_y_i; vx_q <= vel_x_i; vy_q <= vel_y_i;
        r_q <= particle_radius_i; dt_q <= time_step_i;
        edges_q <= '0; walls_q <= '0; idx_q <= '0;
      end
      ST_MY:  x_q <= pwb_pkg::sat32(PW'(x_q) + (mul_p >>> FRAC_BITS));
      ST_ED0: y_q <= pwb_pkg::sat32(PW'(y_q) + (mul_p >>> FRAC_BITS));
      ST_ED1: begin
        // When both edges of an axis are crossed, the low edge wins.
        if (xr < 0 || PW'(x_q) + PW'(r_q) > PW'(arena_w_q)) begin
          vx_q       <= pwb_pkg::sat32(-PW'(vx_q));
          x_q        <= (xr < 0) ? 32'(r_q) : 32'(arena_w_q) - 32'(r_q);
          edges_q[0] <= 1'b1;
        end
        if (yr < 0 || PW'(y_q) + PW'(r_q) > PW'(arena_h_q)) begin
          vy_q       <= pwb_pkg::sat32(-PW'(vy_q));
          y_q        <= (yr < 0) ? 32'(r_q) : 32'(arena_h_q) - 32'(r_q);
          edges_q[1] <= 1'b1;
        end
      end
      ST_WD: begin
        dx_q <= pwb_pkg::clamp31(PW'(rd_q.ex) - PW'(rd_q.sx));
        dy_q <= pwb_pkg::clamp31(PW'(rd_q.ey) - PW'(rd_q.sy));
        px_q <= pwb_pkg::clamp31(nx - PW'(rd_q.sx));
        py_q <= pwb_pkg::clamp31(ny - PW'(rd_q.sy));
      end
      ST_M2: dx2_q <= mul_p[62:0];
      ST_M3: begin
        dy2_q  <= mul_p[62:0];
        len2_q <= 64'(dx2_q) + 64'(mul_p[62:0]);
      end
      ST_M4: dxy_q <= mul_p;
      ST_M5: acc_q <= mul_p;
      ST_M6: begin
        if (dot <= 0) begin
          qx_q <= 34'(rd_q.sx); qy_q <= 34'(rd_q.sy);
        end else begin
          qx_q <= 34'(rd_q.ex); qy_q <= 34'(rd_q.ey);
        end
      end
      ST_DV: if (div_done) t_q <= div_quo;
      ST_T2: qx_q <= 34'(PW'(rd_q.sx) + (mul_p >>> CB));
      ST_T3: qy_q <= 34'(PW'(rd_q.sy) + (mul_p >>> CB));
      ST_WE: begin
        exd_q <= pwb_pkg::clamp32(nx - PW'(qx_q));
        eyd_q <= pwb_pkg::clamp32(ny - PW'(qy_q));
      end
      ST_S2: acc_q <= mul_p;
      ST_S3: acc_q <= sum_acc;
      ST_DC: if (div_done) c_q <= (cn < 0) ? -32'(div_quo) : 32'(div_quo);
      // The sine term is minus twice the product dx*dy, so a positive product flips it.
      ST_DS: if (div_done) s_q <= (dxy_q > 0) ? -32'(div_quo) : 32'(div_quo);
      ST_R2: acc_q <= mul_p;
      ST_R3: acc_q <= acc_q - mul_p;
      ST_R4: begin
        nvx_q <= pwb_pkg::sat32(acc_q >>> CB);
        acc_q <= -mul_p;
      end
      ST_R5: begin
        vx_q <= nvx_q;
        vy_q <= pwb_pkg::sat32((acc_q - mul_p) >>> CB);
        if (idx_q < 7'd8) walls_q[idx_q[2:0]] <= 1'b1;
      end
      ST_NXT: idx_q <= idx_q + 7'd1;
      ST_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          ox_q <= x_q; oy_q <= y_q; ovx_q <= vx_q; ovy_q <= vy_q;
          oedge_q <= edges_q; owall_q <= walls_q;
        end
      end
      default: ;
    endcase
  end

  assign out_valid_o = out_valid_q;
  assign new_x_o     = ox_q;
  assign new_y_o     = oy_q;
  assign new_vx_o    = ovx_q;
  assign new_vy_o    = ovy_q;
  assign edge_hits_o = oedge_q;
  assign wall_hits_o = owall_q;

endmodule
